>>> hw/rtl/bdlp_pkg.sv
package bdlp_pkg;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned EV_W   = 2;
    localparam int unsigned CFG_AW = 2;

    localparam logic [TICK_W-1:0] DEFAULT_SETTLE = TICK_W'(50);

    // event codes
    localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EV_W-1:0] EV_PRESS   = 2'd1;
    localparam logic [EV_W-1:0] EV_RELEASE = 2'd2;
    localparam logic [EV_W-1:0] EV_LONG    = 2'd3;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_LOW_PRESSED = 2'd0;
    localparam logic [CFG_AW-1:0] REG_DEBOUNCE    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_LONG_PRESS  = 2'd2;

    typedef struct packed {
        logic              low_pressed;
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic            level_now;
        logic            held;
        logic [EV_W-1:0] event_res;
    } result_t;

endpackage

>>> hw/rtl/button_debounce_long_press.sv
// Channel   Dir  Beat fields (lowest bit first)
// s_axis    in   tdata: pin_level, 7 bits zero
// m_axis    out  tdata: event_res[1:0], held, level_now, 4 bits zero
// cfg       in   cfg_addr 0 low_pressed, 1 debounce_ticks, 2 long_press_ticks
//
// One beat per clock sustained while m_tready stays high; m_tvalid rises once the s_ accept
// has passed the input register, then the state update into the output register.
// aresetn is synchronous: clears the settle and long-press counts, held state,
// previous level and the valid flags; settings return to 0 / 50 / 0.
// A stall on m_tready holds the output register and backs up through s_tready.
module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // pin_level, pad
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // event_res[1:0], held, level_now, pad
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [TICK_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    logic    in_level_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t res;
    logic    out_free;
    logic    step_en;

    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_pressed      <= 1'b0;
            cfg_reg.debounce_ticks   <= DEFAULT_SETTLE;
            cfg_reg.long_press_ticks <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_LOW_PRESSED: cfg_reg.low_pressed      <= cfg_wdata[0];
                REG_DEBOUNCE:    cfg_reg.debounce_ticks   <= cfg_wdata;
                REG_LONG_PRESS:  cfg_reg.long_press_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tdata[0];
        end
        if (step_en) begin
            out_reg <= res;
        end
    end

    bdlp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .step_en   (step_en),
        .pin_level (in_level_reg),
        .res       (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.level_now, out_reg.held, out_reg.event_res};

endmodule

>>> hw/rtl/bdlp_core.sv
module bdlp_core
    import bdlp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    step_en,
    input  logic    pin_level,
    output result_t res
);

    logic              prev_level_reg, prev_level_next;
    logic [TICK_W-1:0] settle_reg, settle_next;
    logic              held_reg, held_next;
    logic [TICK_W-1:0] hold_reg, hold_next;

    logic              logical;
    logic [TICK_W-1:0] settle_dec;
    logic [TICK_W-1:0] hold_dec;
    logic              deb_event;
    logic [EV_W-1:0]   ev;

    assign logical    = pin_level ^ cfg.low_pressed;
    assign settle_dec = settle_reg - TICK_W'(1);
    assign hold_dec   = hold_reg - TICK_W'(1);

    always_comb begin
        settle_next     = settle_reg;
        held_next       = held_reg;
        hold_next       = hold_reg;
        prev_level_next = pin_level;
        deb_event       = 1'b0;
        ev              = EV_NONE;

        if (pin_level != prev_level_reg) begin
            settle_next = (cfg.debounce_ticks != '0) ? cfg.debounce_ticks : DEFAULT_SETTLE;
        end else if (settle_reg != '0) begin
            settle_next = settle_dec;
            if (settle_dec == '0 && logical != held_reg) begin
                held_next = logical;
                deb_event = 1'b1;
                if (logical) begin
                    hold_next = cfg.long_press_ticks;
                    ev        = EV_PRESS;
                end else begin
                    hold_next = '0;
                    ev        = EV_RELEASE;
                end
            end
        end

        // long-press countdown runs only on ticks without a debounced change
        if (!deb_event && hold_reg != '0) begin
            hold_next = hold_dec;
            if (hold_dec == '0 && held_reg) begin
                ev = EV_LONG;
            end
        end

        res.event_res = ev;
        res.held      = held_next;
        res.level_now = logical;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b0;
            settle_reg     <= '0;
            held_reg       <= 1'b0;
            hold_reg       <= '0;
        end else if (step_en) begin
            prev_level_reg <= prev_level_next;
            settle_reg     <= settle_next;
            held_reg       <= held_next;
            hold_reg       <= hold_next;
        end
    end

    // a running long-press count only exists while pressed
    a_hold_needs_held: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_reg != '0 |-> held_reg)
        else $error("long-press count running while released");

    a_press_sets_held: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.event_res == EV_PRESS |=> held_reg && !$past(held_reg))
        else $error("press without rising held state");

    a_release_clears_held: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.event_res == EV_RELEASE |=> !held_reg && $past(held_reg))
        else $error("release without falling held state");

    a_held_changes_by_event: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && held_next != held_reg |->
            (res.event_res == EV_PRESS || res.event_res == EV_RELEASE))
        else $error("held state changed without an event");

endmodule

>>> tb/bdlp_event_check.sv
`timescale 1ns / 1ps

module bdlp_event_check
    import bdlp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // pin_level, pad
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,   // event_res[1:0], held, level_now, pad
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [TICK_W-1:0] cfg_wdata,
    output int                errors,
    output int                pending
);

    cfg_t              settings;
    logic              last_pin;
    logic              pressed;
    logic [TICK_W-1:0] settle_cnt;
    logic [TICK_W-1:0] hold_cnt;
    result_t           expected_events[$];

    initial errors = 0;
    initial pending = 0;

    // one tick of the debouncer: advances the shadow state, returns the beat
    function automatic result_t debounce_tick(input logic pin);
        result_t r;
        logic    logical;
        logic    fired;
        logical     = settings.low_pressed ? ~pin : pin;
        r.event_res = EV_NONE;
        fired       = 1'b0;
        if (pin != last_pin) begin
            settle_cnt = (settings.debounce_ticks != '0) ? settings.debounce_ticks
                                                         : DEFAULT_SETTLE;
        end else if (settle_cnt != '0) begin
            settle_cnt = settle_cnt - 1'b1;
            if (settle_cnt == '0 && logical != pressed) begin
                pressed = logical;
                fired   = 1'b1;
                if (logical) begin
                    hold_cnt    = settings.long_press_ticks;
                    r.event_res = EV_PRESS;
                end else begin
                    hold_cnt    = '0;
                    r.event_res = EV_RELEASE;
                end
            end
        end
        last_pin = pin;
        // long press only runs on ticks without a debounce event
        if (!fired && hold_cnt != '0) begin
            hold_cnt = hold_cnt - 1'b1;
            if (hold_cnt == '0 && pressed)
                r.event_res = EV_LONG;
        end
        r.held      = pressed;
        r.level_now = logical;
        return r;
    endfunction

    task automatic report(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            settings   = '{low_pressed: 1'b0, debounce_ticks: TICK_W'(50),
                           long_press_ticks: '0};
            last_pin   = 1'b0;
            pressed    = 1'b0;
            settle_cnt = '0;
            hold_cnt   = '0;
            expected_events.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_LOW_PRESSED: settings.low_pressed      = cfg_wdata[0];
                    REG_DEBOUNCE:    settings.debounce_ticks   = cfg_wdata;
                    REG_LONG_PRESS:  settings.long_press_ticks = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_events.push_back(debounce_tick(s_tdata[0]));
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[3:0]);
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_events.pop_front();
                    if (got.event_res != want.event_res)
                        report("event_res", want.event_res, got.event_res);
                    if (got.held != want.held)
                        report("held", want.held, got.held);
                    if (got.level_now != want.level_now)
                        report("level_now", want.level_now, got.level_now);
                end
            end
        end
        pending <= expected_events.size();
    end

endmodule

>>> tb/button_debounce_long_press_tb.sv
`timescale 1ns / 1ps

module button_debounce_long_press_tb;
    import bdlp_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int NUM_PHASES  = 8;
    localparam int MAX_RUN     = 120;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic              cfg_we    = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [TICK_W-1:0] cfg_wdata = '0;

    int   errors;
    int   pending;
    int   sent_cnt  = 0;
    int   quiet     = 0;
    int   rx_gap    = 0;
    int   rx_hold   = 0;
    bit   long_done = 1'b0;
    bit   idle_on   = 1'b1;
    logic pin_now   = 1'b0;

    // first ticks under reset settings, then the hand-made sequence
    bit boot_seq[4]  = '{1, 1, 0, 0};
    bit dir_seq[16]  = '{1, 1, 1, 1, 1, 1, 0, 1, 0, 0, 0, 1, 1, 0, 0, 0};

    bit ph_al[NUM_PHASES]    = '{0, 1, 0, 1, 0, 0, 1, 1};
    int ph_deb[NUM_PHASES]   = '{4, 1, 0, 65535, 0, 2, 0, 3};
    int ph_lp[NUM_PHASES]    = '{6, 1, 12, 65535, 0, 0, 0, 4};
    int ph_items[NUM_PHASES] = '{150, 120, 200, 40, 150, 120, 150, 150};

    always #6 aclk = ~aclk;

    button_debounce_long_press dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    bdlp_event_check event_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    // receiver: short random stalls while idle_on is set, plus one long hold-off to back up the input
    always @(posedge aclk) begin
        if (!long_done && sent_cnt >= 300) begin
            long_done <= 1'b1;
            rx_hold   <= 60;
            m_tready  <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_gap   <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_tick(input logic lvl);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, lvl};
        pin_now  = lvl;
        do @(posedge aclk); while (!s_tready);
        sent_cnt++;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_mode(input bit al, input int deb, input int lp);
        logic [TICK_W-1:0] al_word;
        s_tvalid <= 1'b0;
        wait_drained();
        // polarity only looks at bit 0; upper bits are junk
        al_word    = $urandom;
        al_word[0] = al;
        write_reg(REG_LOW_PRESSED, al_word);
        write_reg(REG_DEBOUNCE, TICK_W'(deb));
        write_reg(REG_LONG_PRESS, TICK_W'(lp));
        cfg_we <= 1'b0;
    endtask

    // button-like runs: bounces, near-threshold holds, long holds, some noise
    task automatic drive_runs(input int n, input int settle, input int hold);
        int done_n;
        int len;
        bit noisy;
        done_n = 0;
        while (done_n < n) begin
            noisy = 1'b0;
            case ($urandom_range(0, 9))
                0, 1:       len = $urandom_range(1, 3);
                2:          len = settle + $urandom_range(0, 1);
                3, 4, 5, 6: len = settle + 1 + $urandom_range(0, hold + 2);
                7, 8:       len = settle + hold + 2 + $urandom_range(0, 5);
                default: begin
                    noisy = 1'b1;
                    len   = $urandom_range(2, 6);
                end
            endcase
            if (len > MAX_RUN) len = MAX_RUN;
            if (len > n - done_n) len = n - done_n;
            if (!noisy) pin_now = ~pin_now;
            repeat (len) begin
                if (noisy) pin_now = $urandom_range(0, 1);
                send_tick(pin_now);
            end
            done_n += len;
        end
    endtask

    initial begin
        ph_al[4]  = $urandom_range(0, 1);
        ph_deb[4] = $urandom_range(1, 8);
        ph_lp[4]  = $urandom_range(0, 15);
        ph_al[6]  = $urandom_range(0, 1);
        ph_deb[6] = $urandom_range(1, 6);
        ph_lp[6]  = $urandom_range(1, 10);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (boot_seq[i]) send_tick(boot_seq[i]);
        set_mode(1'b0, 2, 3);
        foreach (dir_seq[i]) send_tick(dir_seq[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_on = (p != 5) && (p != NUM_PHASES - 1);
            set_mode(ph_al[p], ph_deb[p], ph_lp[p]);
            drive_runs(ph_items[p], (ph_deb[p] == 0) ? 50 : ph_deb[p], ph_lp[p]);
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> button_debounce_long_press.f
hw/rtl/bdlp_pkg.sv
hw/rtl/bdlp_core.sv
hw/rtl/button_debounce_long_press.sv
tb/bdlp_event_check.sv
tb/button_debounce_long_press_tb.sv
